// File: rtl/assert_macros.svh
// assertion macros used by quaternion_to_yaw_pitch_roll.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: rtl/qypr_pkg.sv
// shared constants and the arctangent table for the quaternion angle pipeline
package qypr_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int QUAT_FRAC_BITS_DEF    = 14;
    localparam int ATAN_LEN              = 24;
    localparam int NORM_TOP              = 40;
    localparam int SQRT_STEPS            = 24;
    localparam int SQRT_PER_STAGE        = 2;
    localparam int SQRT_STAGES           = SQRT_STEPS / SQRT_PER_STAGE;
    localparam int RAD_W                 = 2 * SQRT_STEPS;

    // atan(2^-i) in units of pi / 2^31
    function automatic logic signed [31:0] atan_entry(input int unsigned idx);
        logic signed [31:0] r;
        begin
            case (idx)
                0:       r = 32'sd536870912;
                1:       r = 32'sd316933406;
                2:       r = 32'sd167458907;
                3:       r = 32'sd85004756;
                4:       r = 32'sd42667331;
                5:       r = 32'sd21354465;
                6:       r = 32'sd10679838;
                7:       r = 32'sd5340245;
                8:       r = 32'sd2670163;
                9:       r = 32'sd1335087;
                10:      r = 32'sd667544;
                11:      r = 32'sd333772;
                12:      r = 32'sd166886;
                13:      r = 32'sd83443;
                14:      r = 32'sd41722;
                15:      r = 32'sd20861;
                16:      r = 32'sd10430;
                17:      r = 32'sd5215;
                18:      r = 32'sd2608;
                19:      r = 32'sd1304;
                20:      r = 32'sd652;
                21:      r = 32'sd326;
                22:      r = 32'sd163;
                23:      r = 32'sd81;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/quaternion_to_yaw_pitch_roll.sv
// Cordic iterations cap at 24.
// Throughput: one beat per cycle; the whole pipeline holds while an output beat is stalled.
// Depth is set by the 12-stage square root (two root bits a stage) and one cordic
// micro-rotation per stage, the three angle units running side by side.
// Reset clears the valid bits only; data registers are not reset.
`include "assert_macros.svh"

module quaternion_to_yaw_pitch_roll #(
    parameter int CORDIC_ITERATIONS = qypr_pkg::CORDIC_ITERATIONS_DEF,
    parameter int QUAT_FRAC_BITS    = qypr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quat_valid,
    output logic               quat_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               angle_valid,
    input  logic               angle_stall,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] grav_x,
    output logic signed [15:0] grav_y,
    output logic signed [15:0] grav_z
);
    import qypr_pkg::*;

    localparam int Q     = QUAT_FRAC_BITS;
    localparam int ITER  = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    localparam int GW    = 36;
    localparam int NW    = (2 * Q + 2 > 35) ? 2 * Q + 2 : 35;
    localparam int CW    = ((NW > 42) ? NW : 42) + 3;
    localparam int CL    = ITER + 4;
    localparam int TOTAL = SQRT_STAGES + CL + 5;

    localparam logic signed [GW-1:0] SAT_MAX = GW'(32767);
    localparam logic signed [GW-1:0] SAT_MIN = -GW'(32768);

    function automatic logic signed [15:0] sat16(input logic signed [GW-1:0] v);
        logic signed [15:0] r;
        begin
            if (v > SAT_MAX)
            begin
                r = 16'sh7fff;
            end
            else if (v < SAT_MIN)
            begin
                r = 16'sh8000;
            end
            else
            begin
                r = v[15:0];
            end
            return r;
        end
    endfunction

    // pipeline advance and valid chain
    logic             adv;
    logic [TOTAL-1:0] vld_reg;

    assign adv         = !(vld_reg[TOTAL-1] && angle_stall);
    assign quat_stall  = !adv;
    assign angle_valid = vld_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], quat_valid};
        end
    end

    // stage 1: component products
    logic signed [31:0] p_xz_reg, p_wy_reg, p_wx_reg, p_yz_reg, p_ww_reg;
    logic signed [31:0] p_xx_reg, p_yy_reg, p_zz_reg, p_xy_reg, p_wz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xz_reg <= quat_x * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_ww_reg <= quat_w * quat_w;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_wz_reg <= quat_w * quat_z;
        end
    end

    // stage 2: gravity vector with rounding and saturation, yaw operands
    logic signed [GW-1:0] gx_sum, gy_sum, gz_sum;
    logic signed [NW-1:0] nx_next, ny_next, nx_2_reg, ny_2_reg;
    logic signed [15:0]   gx_2_reg, gy_2_reg, gz_2_reg;

    always_comb
    begin
        gx_sum  = (GW'(p_xz_reg) - GW'(p_wy_reg) + (GW'(1) <<< (Q - 2))) >>> (Q - 1);
        gy_sum  = (GW'(p_wx_reg) + GW'(p_yz_reg) + (GW'(1) <<< (Q - 2))) >>> (Q - 1);
        gz_sum  = (GW'(p_ww_reg) - GW'(p_xx_reg) - GW'(p_yy_reg) + GW'(p_zz_reg)
                  + (GW'(1) <<< (Q - 1))) >>> Q;
        nx_next = ((NW'(p_ww_reg) + NW'(p_xx_reg)) <<< 1) - (NW'(1) <<< (2 * Q));
        ny_next = (NW'(p_xy_reg) - NW'(p_wz_reg)) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_2_reg <= sat16(gx_sum);
            gy_2_reg <= sat16(gy_sum);
            gz_2_reg <= sat16(gz_sum);
            nx_2_reg <= nx_next;
            ny_2_reg <= ny_next;
        end
    end

    // stage 3: squares for the pitch magnitude
    logic signed [31:0]   sq_gy_reg, sq_gz_reg;
    logic signed [15:0]   gx_3_reg, gy_3_reg, gz_3_reg;
    logic signed [NW-1:0] nx_3_reg, ny_3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_gy_reg <= gy_2_reg * gy_2_reg;
            sq_gz_reg <= gz_2_reg * gz_2_reg;
            gx_3_reg  <= gx_2_reg;
            gy_3_reg  <= gy_2_reg;
            gz_3_reg  <= gz_2_reg;
            nx_3_reg  <= nx_2_reg;
            ny_3_reg  <= ny_2_reg;
        end
    end

    // stage 4 and square root stages, with the other operands carried along
    logic [RAD_W-1:0]        sq_rad_reg  [SQRT_STAGES+1];
    logic [SQRT_STEPS:0]     sq_rem_reg  [SQRT_STAGES+1];
    logic [SQRT_STEPS-1:0]   sq_root_reg [SQRT_STAGES+1];
    logic signed [15:0]      cy_gx_reg   [SQRT_STAGES+1];
    logic signed [15:0]      cy_gy_reg   [SQRT_STAGES+1];
    logic signed [15:0]      cy_gz_reg   [SQRT_STAGES+1];
    logic signed [NW-1:0]    cy_nx_reg   [SQRT_STAGES+1];
    logic signed [NW-1:0]    cy_ny_reg   [SQRT_STAGES+1];
    logic [31:0]             mag_sum;

    assign mag_sum = 32'(sq_gy_reg) + 32'(sq_gz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad_reg[0]  <= {mag_sum, 16'h0000};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            cy_gx_reg[0]   <= gx_3_reg;
            cy_gy_reg[0]   <= gy_3_reg;
            cy_gz_reg[0]   <= gz_3_reg;
            cy_nx_reg[0]   <= nx_3_reg;
            cy_ny_reg[0]   <= ny_3_reg;
        end
    end

    for (genvar j = 1; j <= SQRT_STAGES; j++)
    begin : g_sqrt
        logic [RAD_W-1:0]      rad;
        logic [SQRT_STEPS+2:0] rem;
        logic [SQRT_STEPS+2:0] trial;
        logic [SQRT_STEPS-1:0] root;

        // two restoring root steps
        always_comb
        begin
            rad  = sq_rad_reg[j-1];
            rem  = (SQRT_STEPS + 3)'(sq_rem_reg[j-1]);
            root = sq_root_reg[j-1];
            for (int s = 0; s < SQRT_PER_STAGE; s++)
            begin
                rem   = {rem[SQRT_STEPS:0], rad[RAD_W-1 -: 2]};
                rad   = rad << 2;
                trial = {1'b0, root, 2'b01};
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = {root[SQRT_STEPS-2:0], 1'b1};
                end
                else
                begin
                    root = {root[SQRT_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[j]  <= rad;
                sq_rem_reg[j]  <= rem[SQRT_STEPS:0];
                sq_root_reg[j] <= root;
                cy_gx_reg[j]   <= cy_gx_reg[j-1];
                cy_gy_reg[j]   <= cy_gy_reg[j-1];
                cy_gz_reg[j]   <= cy_gz_reg[j-1];
                cy_nx_reg[j]   <= cy_nx_reg[j-1];
                cy_ny_reg[j]   <= cy_ny_reg[j-1];
            end
        end
    end

    // three angle units side by side
    logic signed [CW-1:0] pitch_x, pitch_y;
    logic signed [15:0]   yaw_raw, pitch_raw, roll_raw;

    assign pitch_x = CW'($signed({1'b0, sq_root_reg[SQRT_STAGES]}));
    assign pitch_y = CW'(cy_gx_reg[SQRT_STAGES]) <<< 8;

    qypr_cordic #(.CW(CW), .ITER(ITER)) u_yaw (
        .clk   (clk),
        .en    (adv),
        .vec_x (CW'(cy_nx_reg[SQRT_STAGES])),
        .vec_y (CW'(cy_ny_reg[SQRT_STAGES])),
        .angle (yaw_raw)
    );

    qypr_cordic #(.CW(CW), .ITER(ITER)) u_pitch (
        .clk   (clk),
        .en    (adv),
        .vec_x (pitch_x),
        .vec_y (pitch_y),
        .angle (pitch_raw)
    );

    qypr_cordic #(.CW(CW), .ITER(ITER)) u_roll (
        .clk   (clk),
        .en    (adv),
        .vec_x (CW'(cy_gz_reg[SQRT_STAGES])),
        .vec_y (CW'(cy_gy_reg[SQRT_STAGES])),
        .angle (roll_raw)
    );

    // gravity delay line matching the cordic depth
    logic signed [15:0] gd_x_reg [CL];
    logic signed [15:0] gd_y_reg [CL];
    logic signed [15:0] gd_z_reg [CL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gd_x_reg[0] <= cy_gx_reg[SQRT_STAGES];
            gd_y_reg[0] <= cy_gy_reg[SQRT_STAGES];
            gd_z_reg[0] <= cy_gz_reg[SQRT_STAGES];
            for (int k = 1; k < CL; k++)
            begin
                gd_x_reg[k] <= gd_x_reg[k-1];
                gd_y_reg[k] <= gd_y_reg[k-1];
                gd_z_reg[k] <= gd_z_reg[k-1];
            end
        end
    end

    // output beat: pitch replaced by the half turn minus pitch when gz is negative
    logic signed [15:0] yaw_reg, pitch_reg, roll_reg, gx_reg, gy_reg, gz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg   <= yaw_raw;
            pitch_reg <= gd_z_reg[CL-1][15] ? 16'sh8000 - pitch_raw : pitch_raw;
            roll_reg  <= roll_raw;
            gx_reg    <= gd_x_reg[CL-1];
            gy_reg    <= gd_y_reg[CL-1];
            gz_reg    <= gd_z_reg[CL-1];
        end
    end

    assign yaw_angle   = yaw_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign grav_x      = gx_reg;
    assign grav_y      = gy_reg;
    assign grav_z      = gz_reg;

    // checks
    `ASSERT_HOLDS(a_stall_only_on_output, clk, rst_n, quat_stall, angle_valid)
    `ASSERT_NEXT(a_chain_holds, clk, rst_n, quat_stall, $stable(vld_reg))
    `ASSERT_HOLDS(a_zero_gravity, clk, rst_n, angle_valid && grav_x == 16'sd0 && grav_y == 16'sd0 && grav_z == 16'sd0, pitch_angle == 16'sd0 && roll_angle == 16'sd0)

endmodule

// File: rtl/qypr_cordic.sv
// pipelined vectoring cordic: reflect, normalize, iterate, round to a binary angle
module qypr_cordic #(
    parameter int CW   = 45,
    parameter int ITER = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    output logic signed [15:0]   angle
);
    import qypr_pkg::*;

    localparam int NSTG = ITER + 1;

    // stage a: reflect into the right half plane
    logic signed [CW-1:0] a_x_reg, a_y_reg, a_x_next, a_y_next;
    logic        [CW-1:0] a_m_reg, a_m_next;
    logic                 a_zero_reg, a_base_reg;

    always_comb
    begin
        a_x_next = vec_x;
        a_y_next = vec_y;
        if (vec_x < 0)
        begin
            a_x_next = -vec_x;
            a_y_next = -vec_y;
        end
        a_m_next = (a_y_next < 0) ? CW'(-a_y_next) : CW'(a_y_next);
        if (CW'(a_x_next) > a_m_next)
        begin
            a_m_next = CW'(a_x_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= a_x_next;
            a_y_reg    <= a_y_next;
            a_m_reg    <= a_m_next;
            a_zero_reg <= (vec_x == '0) && (vec_y == '0);
            a_base_reg <= vec_x < 0;
        end
    end

    // stage b: coarse normalize by 32, 16, 8
    logic signed [CW-1:0] b_x_reg, b_y_reg, b_x_next, b_y_next;
    logic        [CW-1:0] b_m_reg, b_m_next;
    logic                 b_zero_reg, b_base_reg;

    always_comb
    begin
        b_x_next = a_x_reg;
        b_y_next = a_y_reg;
        b_m_next = a_m_reg;
        for (int k = 0; k < 3; k++)
        begin
            if ((b_m_next >> (NORM_TOP + 1 - (32 >> k))) == '0)
            begin
                b_x_next = b_x_next <<< (32 >> k);
                b_y_next = b_y_next <<< (32 >> k);
                b_m_next = b_m_next << (32 >> k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg    <= b_x_next;
            b_y_reg    <= b_y_next;
            b_m_reg    <= b_m_next;
            b_zero_reg <= a_zero_reg;
            b_base_reg <= a_base_reg;
        end
    end

    // stage c: fine normalize by 4, 2, 1
    logic signed [CW-1:0] it_x_reg [NSTG];
    logic signed [CW-1:0] it_y_reg [NSTG];
    logic signed [31:0]   it_z_reg [NSTG];
    logic                 it_zero_reg [NSTG];
    logic                 it_base_reg [NSTG];
    logic signed [CW-1:0] c_x_next, c_y_next;
    logic        [CW-1:0] c_m_next;

    always_comb
    begin
        c_x_next = b_x_reg;
        c_y_next = b_y_reg;
        c_m_next = b_m_reg;
        for (int k = 0; k < 3; k++)
        begin
            if ((c_m_next >> (NORM_TOP + 1 - (4 >> k))) == '0)
            begin
                c_x_next = c_x_next <<< (4 >> k);
                c_y_next = c_y_next <<< (4 >> k);
                c_m_next = c_m_next << (4 >> k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_x_reg[0]    <= c_x_next;
            it_y_reg[0]    <= c_y_next;
            it_z_reg[0]    <= 32'sd0;
            it_zero_reg[0] <= b_zero_reg;
            it_base_reg[0] <= b_base_reg;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < ITER; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;

        assign dx = it_x_reg[i] >>> i;
        assign dy = it_y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!it_y_reg[i][CW-1])
                begin
                    it_x_reg[i+1] <= it_x_reg[i] + dy;
                    it_y_reg[i+1] <= it_y_reg[i] - dx;
                    it_z_reg[i+1] <= it_z_reg[i] + atan_entry(i);
                end
                else
                begin
                    it_x_reg[i+1] <= it_x_reg[i] - dy;
                    it_y_reg[i+1] <= it_y_reg[i] + dx;
                    it_z_reg[i+1] <= it_z_reg[i] - atan_entry(i);
                end
                it_zero_reg[i+1] <= it_zero_reg[i];
                it_base_reg[i+1] <= it_base_reg[i];
            end
        end
    end

    // round to pi / 2^15 and add the half-turn base
    logic signed [31:0] rnd;
    logic signed [15:0] angle_reg, angle_next;

    always_comb
    begin
        rnd        = it_z_reg[ITER] + 32'sd32768;
        angle_next = rnd[31:16] + (it_base_reg[ITER] ? 16'sh8000 : 16'sh0000);
        if (it_zero_reg[ITER])
        begin
            angle_next = 16'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule
